// ===== rtl/frp_pkg.sv =====
// ----------------------------------------------------------------------------
// frp_pkg: shared types and constants of the field ramp profile
// Register indexes, phase codes, configuration and job words.
// ----------------------------------------------------------------------------
package frp_pkg;

  localparam int TRIG_TABLE_DEPTH = 1024;
  localparam int TIME_BITS        = 32;

  localparam int TIME_W     = 32;
  localparam int SCALE_W    = 18;
  localparam int FRAC_W     = 16;
  localparam int CODE_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int T_W        = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  localparam int BND_W      = TIME_W + 3;
  localparam int DIV_STEPS  = TIME_W - 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [CODE_W-1:0] PH_FILL  = 3'd0;
  localparam logic [CODE_W-1:0] PH_CLEAN = 3'd1;
  localparam logic [CODE_W-1:0] PH_UP    = 3'd2;
  localparam logic [CODE_W-1:0] PH_FULL  = 3'd3;
  localparam logic [CODE_W-1:0] PH_DOWN  = 3'd4;
  localparam logic [CODE_W-1:0] PH_EMPTY = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_FILL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_UP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_DOWN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIP_FRAC  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIP_FREQ  = 3'd7;

  typedef struct packed {
    logic [TIME_W-1:0]  filling_time;
    logic [TIME_W-1:0]  cleaning_time;
    logic [TIME_W-1:0]  ramp_up_time;
    logic [TIME_W-1:0]  full_field_time;
    logic [TIME_W-1:0]  ramp_down_time;
    logic [SCALE_W-1:0] peak_scale;
    logic [FRAC_W-1:0]  ripple_fraction;
    logic [TIME_W-1:0]  ripple_frequency;
  } cfg_t;

  typedef struct packed {
    logic [BND_W-1:0] b1;
    logic [BND_W-1:0] b2;
    logic [BND_W-1:0] b3;
    logic [BND_W-1:0] b4;
    logic [BND_W-1:0] b5;
  } bnd_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              down;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] len;
    logic [TIME_W-1:0] tr;
  } job_t;

endpackage

// ===== rtl/frp_in_if.sv =====
// ----------------------------------------------------------------------------
// frp_in_if: time stamp channel
// Valid/ready channel that carries one time stamp word.
// ----------------------------------------------------------------------------
interface frp_in_if;
  logic                        valid;
  logic                        ready;
  logic [frp_pkg::TIME_W-1:0]  time_ticks;

  modport source (output valid, output time_ticks, input ready);
  modport sink   (input valid, input time_ticks, output ready);
endinterface

// ===== rtl/frp_out_if.sv =====
// ----------------------------------------------------------------------------
// frp_out_if: scale result channel
// Valid/ready channel that carries one scale and phase word.
// ----------------------------------------------------------------------------
interface frp_out_if;
  logic                        valid;
  logic                        ready;
  logic [frp_pkg::SCALE_W-1:0] field_scale;
  logic [frp_pkg::CODE_W-1:0]  phase_code;

  modport source (output valid, output field_scale, output phase_code, input ready);
  modport sink   (input valid, input field_scale, input phase_code, output ready);
endinterface

// ===== rtl/frp_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// frp_cfg_regs: configuration registers
// Holds the phase lengths, peak scale and ripple settings; sums phase bounds.
// ----------------------------------------------------------------------------
module frp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output frp_pkg::cfg_t                   cfg,
  output frp_pkg::bnd_t                   bnd
);
  import frp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.filling_time     <= '0;
      cfg.cleaning_time    <= '0;
      cfg.ramp_up_time     <= '0;
      cfg.full_field_time  <= '0;
      cfg.ramp_down_time   <= '0;
      cfg.peak_scale       <= 18'd65536;
      cfg.ripple_fraction  <= 16'd7;
      cfg.ripple_frequency <= 32'd4295;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILL:      cfg.filling_time     <= cfg_data;
        REG_CLEAN:     cfg.cleaning_time    <= cfg_data;
        REG_RAMP_UP:   cfg.ramp_up_time     <= cfg_data;
        REG_FULL:      cfg.full_field_time  <= cfg_data;
        REG_RAMP_DOWN: cfg.ramp_down_time   <= cfg_data;
        REG_PEAK:      cfg.peak_scale       <= cfg_data[SCALE_W-1:0];
        REG_RIP_FRAC:  cfg.ripple_fraction  <= cfg_data[FRAC_W-1:0];
        REG_RIP_FREQ:  cfg.ripple_frequency <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bnd <= '0;
    end else begin
      bnd.b1 <= BND_W'(cfg.filling_time);
      bnd.b2 <= BND_W'(cfg.filling_time) + BND_W'(cfg.cleaning_time);
      bnd.b3 <= BND_W'(cfg.filling_time) + BND_W'(cfg.cleaning_time)
              + BND_W'(cfg.ramp_up_time);
      bnd.b4 <= BND_W'(cfg.filling_time) + BND_W'(cfg.cleaning_time)
              + BND_W'(cfg.ramp_up_time) + BND_W'(cfg.full_field_time);
      bnd.b5 <= BND_W'(cfg.filling_time) + BND_W'(cfg.cleaning_time)
              + BND_W'(cfg.ramp_up_time) + BND_W'(cfg.full_field_time)
              + BND_W'(cfg.ramp_down_time);
    end
  end

endmodule

// ===== rtl/frp_front.sv =====
// ----------------------------------------------------------------------------
// frp_front: time stamp intake and phase classification
// Registers a time stamp, finds its phase and the ramp offset and length.
// ----------------------------------------------------------------------------
module frp_front (
  input  logic           clk,
  input  logic           rst,
  input  frp_pkg::cfg_t  cfg,
  input  frp_pkg::bnd_t  bnd,
  frp_in_if.sink         samples,
  output frp_pkg::job_t  job,
  output logic           job_valid,
  input  logic           job_ready
);
  import frp_pkg::*;

  logic             held;
  logic [T_W-1:0]   t;
  logic [BND_W-1:0] tc;
  logic [BND_W-1:0] e_up;
  logic [BND_W-1:0] e_dn;

  assign samples.ready = !held || job_ready;
  assign job_valid     = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (samples.ready) begin
      held <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      t <= samples.time_ticks[T_W-1:0];
    end
  end

  always_comb begin
    tc       = BND_W'(t);
    e_up     = tc - bnd.b2;
    e_dn     = tc - bnd.b4;
    job.tr   = TIME_W'(t);
    job.down = 1'b0;
    job.len  = cfg.ramp_up_time;
    job.elapsed = e_up[TIME_W-1:0];
    if (tc < bnd.b1) begin
      job.code = PH_FILL;
    end else if (tc < bnd.b2) begin
      job.code = PH_CLEAN;
    end else if (tc < bnd.b3) begin
      job.code = PH_UP;
    end else if (tc < bnd.b4) begin
      job.code = PH_FULL;
    end else if (tc < bnd.b5) begin
      job.code    = PH_DOWN;
      job.down    = 1'b1;
      job.len     = cfg.ramp_down_time;
      job.elapsed = e_dn[TIME_W-1:0];
    end else begin
      job.code = PH_EMPTY;
    end
  end

endmodule

// ===== rtl/frp_queue.sv =====
// ----------------------------------------------------------------------------
// frp_queue: job queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module frp_queue (
  input  logic           clk,
  input  logic           rst,
  input  frp_pkg::job_t  push_job,
  input  logic           push_valid,
  output logic           push_ready,
  output frp_pkg::job_t  pop_job,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import frp_pkg::*;

  job_t              slots [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QPTR_W:0]   cnt;
  logic              push;
  logic              pop;

  assign push_ready = cnt != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_job    = slots[rp];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_job;
  end

endmodule

// ===== rtl/frp_back.sv =====
// ----------------------------------------------------------------------------
// frp_back: ramp and ripple pipeline
// Divides out the ramp phase, looks up sine and cosine, scales and ripples.
// ----------------------------------------------------------------------------
module frp_back (
  input  logic           clk,
  input  logic           rst,
  input  frp_pkg::cfg_t  cfg,
  input  frp_pkg::job_t  job,
  input  logic           job_valid,
  output logic           job_ready,
  frp_out_if.source      results
);
  import frp_pkg::*;

  localparam int IDX_W = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int MAG_W = 17;
  localparam int TAIL  = 8;

  typedef longint unsigned u64_t;
  typedef logic [MAG_W-1:0] sine_rom_t [0:TRIG_TABLE_DEPTH];

  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t DEPTH_U     = u64_t'(TRIG_TABLE_DEPTH);
  localparam int   RECIP_SH    = 43;
  localparam u64_t TAYLOR_RECIP [0:8] = '{
    (64'd1 << RECIP_SH) / 64'd6   + 64'd1, (64'd1 << RECIP_SH) / 64'd20  + 64'd1,
    (64'd1 << RECIP_SH) / 64'd42  + 64'd1, (64'd1 << RECIP_SH) / 64'd72  + 64'd1,
    (64'd1 << RECIP_SH) / 64'd110 + 64'd1, (64'd1 << RECIP_SH) / 64'd156 + 64'd1,
    (64'd1 << RECIP_SH) / 64'd210 + 64'd1, (64'd1 << RECIP_SH) / 64'd272 + 64'd1,
    (64'd1 << RECIP_SH) / 64'd342 + 64'd1};

  function automatic sine_rom_t build_sine();
    sine_rom_t    tbl;
    u64_t         x;
    u64_t         x2;
    u64_t         term;
    u64_t         q;
    logic [127:0] wide;
    longint       sum;
    for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * u64_t'(k) + (DEPTH_U >> 1)) / DEPTH_U;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        wide = 128'((term * x2) >> 30) * 128'(TAYLOR_RECIP[n-1]);
        term = u64_t'(wide >> RECIP_SH);
        if ((n & 1) == 1) sum = sum - longint'(term);
        else              sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      q = u64_t'(sum + 8192) >> 14;
      if (q > 64'd65536) q = 64'd65536;
      tbl[k] = MAG_W'(q);
    end
    return tbl;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  function automatic logic [IDX_W-1:0] quad_index(input logic [TIME_W-1:0] p);
    logic [47:0] prod;
    logic [17:0] idx;
    prod = 48'(p[29:0]) * 48'(TRIG_TABLE_DEPTH) + 48'(32'h2000_0000);
    idx  = prod[47:30];
    if (idx > 18'(TRIG_TABLE_DEPTH)) idx = 18'(TRIG_TABLE_DEPTH);
    if (p[30]) idx = 18'(TRIG_TABLE_DEPTH) - idx;
    return idx[IDX_W-1:0];
  endfunction

  typedef struct packed {
    logic [CODE_W-1:0]    code;
    logic                 down;
    logic [TIME_W:0]      rem;
    logic [TIME_W-1:0]    len;
    logic [DIV_STEPS-1:0] quo;
    logic [TIME_W-1:0]    rp;
  } dstage_t;

  dstage_t ds      [0:DIV_STEPS];
  dstage_t ds_next [1:DIV_STEPS];

  logic [DIV_STEPS:0] dv;
  logic [TAIL-1:0]    sv;
  logic               ov;
  logic               adv;
  logic [TIME_W-1:0]  rp_low;

  logic [CODE_W-1:0]  l0_code, l1_code, m0_code, m1_code, m2_code, m3_code, m4_code, m5_code;
  logic               l0_down, l1_down;
  logic [IDX_W-1:0]   l0_ic, l0_is;
  logic               l0_nc, l0_ns, l1_cneg, l1_sneg, m0_sneg, m1_sneg, m2_sneg, m3_sneg;
  logic [MAG_W-1:0]   l1_cmag, l1_smag, m0_smag, m1_smag, m2_smag;
  logic [35:0]        m0_prod;
  logic [SCALE_W-1:0] m1_scale, m2_scale, m3_scale, m4_scale;
  logic [33:0]        m2_sf;
  logic [50:0]        m3_x;
  logic [19:0]        m4_factor;
  logic               m4_kill, m5_kill;
  logic [38:0]        m5_res;
  logic [SCALE_W-1:0] o_scale;
  logic [CODE_W-1:0]  o_code;

  logic [TIME_W-1:0]  p_ramp;
  logic [TIME_W-1:0]  p_cos;
  logic [SCALE_W:0]   w;
  logic [35:0]        pr;
  logic [SCALE_W-1:0] scale_sel;
  logic [50:0]        rx;
  logic [18:0]        r;
  logic [19:0]        factor;
  logic               kill;
  logic [38:0]        rr;
  logic [22:0]        sh;
  logic [SCALE_W-1:0] scale_out;

  assign adv       = !ov || results.ready;
  assign job_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
      sv <= '0;
      ov <= 1'b0;
    end else if (adv) begin
      dv <= {dv[DIV_STEPS-1:0], job_valid};
      sv <= {sv[TAIL-2:0], dv[DIV_STEPS]};
      ov <= sv[TAIL-1];
    end
  end

  assign rp_low = cfg.ripple_frequency * job.tr;

  always_comb begin
    for (int i = 1; i <= DIV_STEPS; i++) begin
      ds_next[i]     = ds[i-1];
      ds_next[i].rem = {ds[i-1].rem[TIME_W-1:0], 1'b0};
      if (ds_next[i].rem >= {1'b0, ds[i-1].len}) begin
        ds_next[i].rem = ds_next[i].rem - {1'b0, ds[i-1].len};
        ds_next[i].quo = {ds[i-1].quo[DIV_STEPS-2:0], 1'b1};
      end else begin
        ds_next[i].quo = {ds[i-1].quo[DIV_STEPS-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    p_ramp = TIME_W'(ds[DIV_STEPS].quo);
    p_cos  = p_ramp + 32'h4000_0000;

    if (l1_down ^ l1_cneg) w = 19'd65536 + 19'(l1_cmag);
    else                   w = 19'd65536 - 19'(l1_cmag);

    pr = m0_prod + 36'd65536;
    if (m0_code == PH_UP || m0_code == PH_DOWN) begin
      scale_sel = pr[34:17];
    end else if (m0_code == PH_FULL) begin
      scale_sel = cfg.peak_scale;
    end else begin
      scale_sel = '0;
    end

    rx = m3_x + 51'h8000_0000;
    r  = rx[50:32];
    if (m3_sneg) begin
      kill   = r >= 19'd65536;
      factor = 20'd65536 - 20'(r);
    end else begin
      kill   = 1'b0;
      factor = 20'd65536 + 20'(r);
    end

    rr = m5_res + 39'd32768;
    sh = rr[38:16];
    if (m5_kill) begin
      scale_out = '0;
    end else if (sh > 23'(18'h3FFFF)) begin
      scale_out = 18'h3FFFF;
    end else begin
      scale_out = sh[SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0].code <= job.code;
      ds[0].down <= job.down;
      ds[0].rem  <= (TIME_W+1)'(job.elapsed);
      ds[0].len  <= job.len;
      ds[0].quo  <= '0;
      ds[0].rp   <= rp_low;
      for (int i = 1; i <= DIV_STEPS; i++) begin
        ds[i] <= ds_next[i];
      end

      l0_code <= ds[DIV_STEPS].code;
      l0_down <= ds[DIV_STEPS].down;
      l0_ic   <= quad_index(p_cos);
      l0_nc   <= p_cos[31];
      l0_is   <= quad_index(ds[DIV_STEPS].rp);
      l0_ns   <= ds[DIV_STEPS].rp[31];

      l1_code <= l0_code;
      l1_down <= l0_down;
      l1_cmag <= SINE_ROM[l0_ic];
      l1_cneg <= l0_nc;
      l1_smag <= SINE_ROM[l0_is];
      l1_sneg <= l0_ns;

      m0_code <= l1_code;
      m0_prod <= 36'(w) * 36'(cfg.peak_scale);
      m0_smag <= l1_smag;
      m0_sneg <= l1_sneg;

      m1_code  <= m0_code;
      m1_scale <= scale_sel;
      m1_smag  <= m0_smag;
      m1_sneg  <= m0_sneg;

      m2_code  <= m1_code;
      m2_scale <= m1_scale;
      m2_sf    <= 34'(m1_scale) * 34'(cfg.ripple_fraction);
      m2_smag  <= m1_smag;
      m2_sneg  <= m1_sneg;

      m3_code  <= m2_code;
      m3_scale <= m2_scale;
      m3_x     <= 51'(m2_sf) * 51'(m2_smag);
      m3_sneg  <= m2_sneg;

      m4_code   <= m3_code;
      m4_scale  <= m3_scale;
      m4_factor <= factor;
      m4_kill   <= kill;

      m5_code <= m4_code;
      m5_res  <= 39'(m4_scale) * 39'(m4_factor);
      m5_kill <= m4_kill;

      o_scale <= scale_out;
      o_code  <= m5_code;
    end
  end

  assign results.valid       = ov;
  assign results.field_scale = o_scale;
  assign results.phase_code  = o_code;

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.phase_code <= PH_EMPTY)
    else $error("phase code out of range");

  a_zero_phases: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.phase_code == PH_FILL || results.phase_code == PH_CLEAN ||
                      results.phase_code == PH_EMPTY) |-> results.field_scale == '0)
    else $error("nonzero scale in a field-free phase");

  a_full_plain: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.phase_code == PH_FULL && cfg.ripple_fraction == '0
    |-> results.field_scale == cfg.peak_scale)
    else $error("full-field scale differs from peak without ripple");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({dv, sv, ov}))
    else $error("pipeline moved while stalled");

endmodule

// ===== rtl/field_ramp_profile.sv =====
// ----------------------------------------------------------------------------
// field_ramp_profile: field scale factor over one experiment cycle
// Throughput: one word per cycle while the result receiver is ready;
// the 31-stage phase divider sets the depth.
// A four-word queue decouples intake from the divider and scale pipeline.
// Reset clears all valid state and loads the register defaults.
// ----------------------------------------------------------------------------
module field_ramp_profile (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [frp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [frp_pkg::CFG_DATA_W-1:0]  cfg_data,
  frp_in_if.sink                          samples,
  frp_out_if.source                       results
);
  import frp_pkg::*;

  cfg_t cfg;
  bnd_t bnd;
  job_t f_job;
  job_t q_job;
  logic f_valid;
  logic f_ready;
  logic q_valid;
  logic q_ready;

  frp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .bnd       (bnd)
  );

  frp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .bnd       (bnd),
    .samples   (samples),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  frp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (f_job),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_job    (q_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  frp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .results   (results)
  );

endmodule

// ===== tb/sv/tb_field_ramp_profile.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_field_ramp_profile: self-checking bench for the field ramp profile
// Sweeps phase lengths, peak scale and ripple settings. Each time word
// accepted is scored against a fixed-point scale and phase predictor; result
// words are compared in order. Random idling on both channels, one long
// receiver hold-off, and an idle drain before every register update.
// ----------------------------------------------------------------------------
module tb_field_ramp_profile;
  import frp_pkg::*;

  localparam int  HALF_PI_Q30 = 1686629713;
  localparam int  N_SETS      = 8;
  localparam int  SET_ITEMS   = 150;
  localparam int  CYCLE_LIMIT = 1000000;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [SCALE_W-1:0] scale;
    logic [CODE_W-1:0]  code;
  } scale_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  frp_in_if  samples();
  frp_out_if results();

  field_ramp_profile uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samples(samples), .results(results)
  );

  always #5 clk = ~clk;

  longint unsigned sine_lut [0:TRIG_TABLE_DEPTH];
  logic [31:0] regs [0:7];
  logic [TIME_W-1:0] pending_times[$];
  scale_word_t expected_words[$];

  int errors = 0;
  int cycles = 0;
  int words_checked = 0;
  int code_hits [0:7];
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_cnt = 0;
  int gap_cnt = 0;
  int stall_cnt = 0;

  function automatic void build_lut();
    longint unsigned x, x2, term, q;
    longint sum;
    for (int k = 0; k <= TRIG_TABLE_DEPTH; k++) begin
      x = (longint'(HALF_PI_Q30) * k + TRIG_TABLE_DEPTH / 2) / TRIG_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 9; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      q = (u64_t'(sum) + 8192) >> 14;
      if (q > 65536) q = 65536;
      sine_lut[k] = q;
    end
  endfunction

  function automatic longint sine_of(logic [31:0] p);
    longint unsigned pos, idx;
    longint v;
    pos = p[29:0];
    idx = (pos * TRIG_TABLE_DEPTH + (64'd1 << 29)) >> 30;
    if (idx > TRIG_TABLE_DEPTH) idx = TRIG_TABLE_DEPTH;
    if (p[30]) idx = TRIG_TABLE_DEPTH - idx;
    v = longint'(sine_lut[idx]);
    return p[31] ? -v : v;
  endfunction

  function automatic longint unsigned ramp_value(longint unsigned elapsed,
                                                 longint unsigned len, bit down);
    logic [31:0] p;
    longint c, w;
    p = 32'((elapsed << 31) / len);
    c = sine_of(p + 32'h4000_0000);
    w = down ? (65536 + c) : (65536 - c);
    return (u64_t'(w) * regs[REG_PEAK][SCALE_W-1:0] + 65536) >> 17;
  endfunction

  function automatic scale_word_t field_scale_of(logic [TIME_W-1:0] tt);
    longint unsigned t, b1, b2, b3, b4, b5, scale, frac, mag, r;
    longint s, factor;
    logic [31:0] p;
    scale_word_t w;
    t = tt;
    frac = regs[REG_RIP_FRAC][FRAC_W-1:0];
    b1 = regs[REG_FILL];
    b2 = b1 + regs[REG_CLEAN];
    b3 = b2 + regs[REG_RAMP_UP];
    b4 = b3 + regs[REG_FULL];
    b5 = b4 + regs[REG_RAMP_DOWN];
    if (t < b1) begin
      w.code = PH_FILL; scale = 0;
    end else if (t < b2) begin
      w.code = PH_CLEAN; scale = 0;
    end else if (t < b3) begin
      w.code = PH_UP; scale = ramp_value(t - b2, regs[REG_RAMP_UP], 1'b0);
    end else if (t < b4) begin
      w.code = PH_FULL; scale = regs[REG_PEAK][SCALE_W-1:0];
    end else if (t < b5) begin
      w.code = PH_DOWN; scale = ramp_value(t - b4, regs[REG_RAMP_DOWN], 1'b1);
    end else begin
      w.code = PH_EMPTY; scale = 0;
    end
    if (frac != 0) begin
      p = regs[REG_RIP_FREQ] * tt;
      s = sine_of(p);
      mag = (s < 0) ? u64_t'(-s) : u64_t'(s);
      r = (scale * frac * mag + 64'h8000_0000) >> 32;
      factor = (s < 0) ? (65536 - longint'(r)) : (65536 + longint'(r));
      if (factor <= 0) scale = 0;
      else scale = (scale * u64_t'(factor) + 32768) >> 16;
    end
    if (scale > 262143) scale = 262143;
    w.scale = scale[SCALE_W-1:0];
    return w;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else if (!samples.valid || samples.ready) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        samples.valid <= 1'b0;
      end else if (pending_times.size() > 0) begin
        samples.valid <= 1'b1;
        samples.time_ticks <= pending_times.pop_front();
        if (!quiet && $urandom_range(0, 11) == 0) gap_cnt <= $urandom_range(1, 19);
      end else begin
        samples.valid <= 1'b0;
      end
    end
  end

  // receiver idling and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      results.ready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      results.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      results.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      results.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      stall_cnt <= $urandom_range(0, 18);
      results.ready <= 1'b0;
    end else begin
      results.ready <= 1'b1;
    end
  end

  // predict on intake, score on output
  always @(posedge clk) begin
    scale_word_t want;
    if (!rst && samples.valid && samples.ready)
      expected_words = {expected_words, field_scale_of(samples.time_ticks)};
    if (!rst && results.valid && results.ready) begin
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word scale=%0d code=%0d",
                                   results.field_scale, results.phase_code);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        code_hits[want.code]++;
        if (results.field_scale !== want.scale || results.phase_code !== want.code) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected scale=%0d code=%0d, got scale=%0d code=%0d",
                     want.scale, want.code, results.field_scale, results.phase_code);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    regs[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_times.size() != 0 || samples.valid || expected_words.size() != 0);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom;
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    longint unsigned b [0:5];
    longint unsigned v, span;
    b[0] = 0;
    for (int i = 1; i <= 5; i++) b[i] = b[i-1] + regs[i-1];
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        v = b[$urandom_range(0, 5)] + $urandom_range(0, 40);
        v = (v < 20) ? 0 : v - 20;
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      end
      default: begin
        span = (b[5] > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : b[5];
        v = {$urandom, $urandom};
        return 32'(v % (span + 1));
      end
    endcase
  endfunction

  task automatic load_set(int set_no);
    case (set_no)
      0: ;
      1: begin
        write_reg(REG_FILL, 10); write_reg(REG_CLEAN, 5);
        write_reg(REG_RAMP_UP, 100); write_reg(REG_FULL, 50);
        write_reg(REG_RAMP_DOWN, 100); write_reg(REG_PEAK, 65536);
        write_reg(REG_RIP_FRAC, 0); write_reg(REG_RIP_FREQ, 0);
      end
      2: begin
        for (int i = 0; i < 5; i++) write_reg(i, 32'hFFFF_FFFF);
        write_reg(REG_PEAK, 262143); write_reg(REG_RIP_FRAC, 65535);
        write_reg(REG_RIP_FREQ, 32'hFFFF_FFFF);
      end
      3: begin
        write_reg(REG_FILL, 0); write_reg(REG_CLEAN, 0);
        write_reg(REG_RAMP_UP, 1); write_reg(REG_FULL, 0);
        write_reg(REG_RAMP_DOWN, 1); write_reg(REG_PEAK, 0);
        write_reg(REG_RIP_FRAC, 1); write_reg(REG_RIP_FREQ, 1);
      end
      4: begin
        write_reg(REG_FILL, 20); write_reg(REG_CLEAN, 20);
        write_reg(REG_RAMP_UP, 300); write_reg(REG_FULL, 30);
        write_reg(REG_RAMP_DOWN, 300); write_reg(REG_PEAK, 131072);
        write_reg(REG_RIP_FRAC, 65535); write_reg(REG_RIP_FREQ, 32'h0200_0000);
      end
      default: begin
        for (int i = 0; i < 5; i++) write_reg(i, pick_len());
        write_reg(REG_PEAK, $urandom_range(0, 262143));
        write_reg(REG_RIP_FRAC, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535));
        write_reg(REG_RIP_FREQ, $urandom);
      end
    endcase
  endtask

  initial begin
    longint unsigned edge_t;
    build_lut();
    regs[0] = 0; regs[1] = 0; regs[2] = 0; regs[3] = 0; regs[4] = 0;
    regs[REG_PEAK] = 65536; regs[REG_RIP_FRAC] = 7; regs[REG_RIP_FREQ] = 4295;
    for (int i = 0; i < 8; i++) code_hits[i] = 0;
    samples.valid = 1'b0;
    samples.time_ticks = '0;
    results.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    for (int s = 0; s < N_SETS; s++) begin
      load_set(s);
      if (s == N_SETS - 1) quiet = 1'b1;
      pending_times = {pending_times, 32'd0};
      pending_times = {pending_times, 32'd1};
      pending_times = {pending_times, 32'h8000_0000};
      pending_times = {pending_times, 32'hFFFF_FFFF};
      edge_t = 0;
      for (int i = 0; i < 5; i++) begin
        edge_t += regs[i];
        if (edge_t <= 64'hFFFF_FFFF) begin
          pending_times = {pending_times, edge_t[31:0]};
          if (edge_t > 0) pending_times = {pending_times, 32'(edge_t - 1)};
        end
      end
      for (int i = 0; i < SET_ITEMS; i++) pending_times = {pending_times, pick_time()};
      if (s == 4) hold_go = 1'b1;
      drain();
    end
    $display("checked %0d result words over %0d register sets", words_checked, N_SETS);
    $display("phase hits fill/clean/up/full/down/empty: %0d %0d %0d %0d %0d %0d",
             code_hits[PH_FILL], code_hits[PH_CLEAN], code_hits[PH_UP],
             code_hits[PH_FULL], code_hits[PH_DOWN], code_hits[PH_EMPTY]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
